FILE: sv/kaau_pkg.sv
// shared types, constants and codes for the k-means assign/accumulate/update block
package kaau_pkg;

	localparam int CLUSTERS_DEF = 16;
	localparam int DIMS_DEF     = 16;
	localparam int ADDR_LIMIT   = 16;

	localparam int VAL_W  = 16;
	localparam int SUM_W  = 48;
	localparam int CNT_W  = 32;
	localparam int DIST_W = 38;
	localparam int LL_W   = 37;
	localparam int WGT_W  = 17;

	// input transaction kinds
	localparam logic [2:0] KIND_WRITE  = 3'd0;
	localparam logic [2:0] KIND_SAMPLE = 3'd1;
	localparam logic [2:0] KIND_BEGIN  = 3'd2;
	localparam logic [2:0] KIND_FINISH = 3'd3;
	localparam logic [2:0] KIND_READ   = 3'd4;

	// result kinds
	localparam logic [1:0] RES_ASSIGN = 2'd0;
	localparam logic [1:0] RES_UPDATE = 2'd1;
	localparam logic [1:0] RES_READ   = 2'd2;
	localparam logic [1:0] RES_NONE   = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_CLUSTERS = 2'd0;
	localparam logic [1:0] CFG_DIMS     = 2'd1;
	localparam logic [1:0] CFG_SEED     = 2'd2;

	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [SUM_W-1:0] quotient;
	} div_rsp_t;

endpackage

FILE: sv/kaau_ram.sv
// generic simple dual-port ram with registered read
module kaau_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: sv/kaau_div.sv
// restoring unsigned divider, one quotient bit per cycle
module kaau_div (
	input  logic               clk,
	input  logic               arst_n,
	input  kaau_pkg::div_req_t req,
	output kaau_pkg::div_rsp_t rsp
);
	import kaau_pkg::*;

	localparam int CW = $clog2(SUM_W + 1);

	logic [SUM_W-1:0] quo_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] dvs_q;
	logic [CW-1:0]    cnt_q;
	logic             done_q;
	logic [CNT_W:0]   shifted;
	logic             fits;

	assign shifted = {rem_q, quo_q[SUM_W-1]};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= CW'(SUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[SUM_W-2:0], fits};
			rem_q <= fits ? CNT_W'(shifted - {1'b0, dvs_q}) : shifted[CNT_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

FILE: sv/kmeans_assign_accumulate_update.sv
// top level: one pass of lloyd k-means in q8.8 with a shared multiplier and divider
//
//  channel | direction | handshake            | payload
//  in      | into      | in_valid / in_stall  | kind, cluster_index, dim_index, value
//  out     | out of    | out_valid / out_stall| result_kind .. last
//  cfg     | into      | cfg_we               | cfg_index, cfg_data
//
// a write, begin or non-final sample is taken in idle; a read adds S_RDA and S_RDOUT
// the final sample component is paced by
//   the single 17x17 multiplier stepping through every component of every centroid
// a finish is paced by the one-bit-per-cycle divider
// reset makes every sum read as zero at once through per-cluster fresh bits; no sweep
// the block stalls its input while it works; a held result stalls it only once the
//   next result needs the output register
module kmeans_assign_accumulate_update #(
	parameter int CLUSTERS = kaau_pkg::CLUSTERS_DEF,
	parameter int DIMS     = kaau_pkg::DIMS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input transactions
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [2:0]           kind,
	input  logic [3:0]           cluster_index,
	input  logic [3:0]           dim_index,
	input  logic signed [15:0]   value,
	// results
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           result_kind,
	output logic [3:0]           cluster_index_res,
	output logic signed [36:0]   log_likelihood,
	output logic signed [15:0]   read_value,
	output logic [16:0]          weight,
	output logic                 empty_res,
	output logic                 last,
	// configuration
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_data
);
	import kaau_pkg::*;

	// effective sizes: ports address at most 16 of each
	localparam int EC = (CLUSTERS < ADDR_LIMIT) ? CLUSTERS : ADDR_LIMIT;
	localparam int ED = (DIMS < ADDR_LIMIT) ? DIMS : ADDR_LIMIT;
	localparam int CW = (EC > 1) ? $clog2(EC) : 1;
	localparam int DW = (ED > 1) ? $clog2(ED) : 1;
	localparam int AW = CW + DW;
	localparam int NROW = 1 << CW;
	localparam int NBUF = 1 << DW;

	localparam logic signed [SUM_W:0] SUM_HI = {2'b00, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W:0] SUM_LO = {2'b11, {(SUM_W-1){1'b0}}};
	localparam logic [DIST_W-1:0] DIST_SAT = DIST_W'(64'd1 << 36);

	typedef enum logic [14:0] {
		S_IDLE  = 15'b000000000000001,
		S_DRD   = 15'b000000000000010,
		S_DMUL  = 15'b000000000000100,
		S_DACC  = 15'b000000000001000,
		S_DCMP  = 15'b000000000010000,
		S_CNT   = 15'b000000000100000,
		S_SRD   = 15'b000000001000000,
		S_SWR   = 15'b000000010000000,
		S_AOUT  = 15'b000000100000000,
		S_RDA   = 15'b000001000000000,
		S_RDOUT = 15'b000010000000000,
		S_FCHK  = 15'b000100000000000,
		S_FRD   = 15'b001000000000000,
		S_FDW   = 15'b010000000000000,
		S_FW    = 15'b100000000000000
	} state_t;

	// extra finish states kept apart to hold the one-hot width readable
	typedef enum logic [2:0] {
		F_NONE = 3'b001,
		F_DS   = 3'b010,
		F_WW   = 3'b100
	} fsub_t;

	state_t state_q;
	fsub_t  fsub_q;

	// configuration registers
	logic [4:0]         act_clusters_q;
	logic [4:0]         act_dims_q;
	logic signed [15:0] sum_seed_q;
	logic signed [15:0] pass_seed_q;

	// latched transaction
	logic [3:0]         ci_q;
	logic [3:0]         di_q;

	// loop and datapath state
	logic [4:0]          j_q;
	logic [4:0]          k_q;
	logic [4:0]          comp_cnt_q;
	logic signed [15:0]  buf_q [NBUF];
	logic [32:0]         prod_s1;
	logic [DIST_W-1:0]   acc_q;
	logic [DIST_W-1:0]   bestd_q;
	logic [3:0]          best_q;
	logic [CNT_W-1:0]    counts_q [NROW];
	logic [CNT_W-1:0]    total_q;
	logic [NROW-1:0]     fresh_q;
	logic                neg_q;
	logic [CNT_W-1:0]    cur_cnt_q;
	logic [WGT_W-1:0]    wgt_q;

	// output register
	logic                out_valid_q;
	logic                slot_free;
	logic                emit;

	// effective active counts
	logic [4:0] nc;
	logic [4:0] nd;
	always_comb begin
		nc = (act_clusters_q == '0) ? 5'd1 : act_clusters_q;
		if (nc > 5'(EC)) nc = 5'(EC);
		nd = (act_dims_q == '0) ? 5'd1 : act_dims_q;
		if (nd > 5'(ED)) nd = 5'(ED);
	end

	assign in_stall  = (state_q != S_IDLE);
	assign slot_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// a result is loaded into the output register this cycle
	assign emit = slot_free && ((state_q == S_AOUT) || (state_q == S_RDOUT)
		|| (state_q == S_FW && fsub_q == F_DS));

	logic accept;
	assign accept = in_valid && !in_stall;

	// centroid and sum memories
	logic                cen_we, cen_re;
	logic [AW-1:0]       cen_waddr, cen_raddr;
	logic signed [15:0]  cen_wdata, cen_rdata;
	logic                sum_we, sum_re;
	logic [AW-1:0]       sum_waddr, sum_raddr;
	logic [SUM_W-1:0]    sum_wdata, sum_rdata;

	kaau_ram #(.WIDTH(VAL_W), .DEPTH(1 << AW)) u_cen_ram (
		.clk   (clk),
		.we    (cen_we),
		.waddr (cen_waddr),
		.wdata (cen_wdata),
		.re    (cen_re),
		.raddr (cen_raddr),
		.rdata (cen_rdata)
	);

	kaau_ram #(.WIDTH(SUM_W), .DEPTH(1 << AW)) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wdata),
		.re    (sum_re),
		.raddr (sum_raddr),
		.rdata (sum_rdata)
	);

	div_req_t div_req;
	div_rsp_t div_rsp;

	kaau_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// helpers of the datapath
	logic                in_range_w;
	logic                in_range_q;
	logic signed [16:0]  z;
	logic signed [SUM_W-1:0] sum_old;
	logic signed [SUM_W:0]   sum_add;
	logic [SUM_W-1:0]    sum_new;
	logic [SUM_W-1:0]    mag;
	logic signed [15:0]  mean;
	logic [CNT_W-1:0]    row_cnt;
	logic                j_last, k_last_nd, k_last_ed;

	assign in_range_w = ({1'b0, cluster_index} < 5'(EC)) && ({1'b0, dim_index} < 5'(ED));
	assign z       = 17'(buf_q[k_q[DW-1:0]]) - 17'(cen_rdata);
	assign row_cnt = counts_q[j_q[CW-1:0]];
	assign j_last    = (j_q + 5'd1) >= nc;
	assign k_last_nd = (k_q + 5'd1) >= nd;
	assign k_last_ed = (k_q + 5'd1) >= 5'(ED);

	// sum row reads as the pass seed until its first write in a pass
	always_comb begin
		logic [CW-1:0] row;
		row     = (state_q == S_SWR) ? best_q[CW-1:0] : j_q[CW-1:0];
		sum_old = fresh_q[row] ? SUM_W'(pass_seed_q) : sum_rdata;
		sum_add = (SUM_W+1)'(sum_old) + (SUM_W+1)'(buf_q[k_q[DW-1:0]]);
		if (k_q >= nd) begin
			sum_new = sum_old;
		end else if (sum_add > SUM_HI) begin
			sum_new = SUM_HI[SUM_W-1:0];
		end else if (sum_add < SUM_LO) begin
			sum_new = SUM_LO[SUM_W-1:0];
		end else begin
			sum_new = sum_add[SUM_W-1:0];
		end
		mag = sum_old[SUM_W-1] ? SUM_W'(-sum_old) : sum_old;
	end

	// truncated quotient, signed and saturated to q8.8
	always_comb begin
		if (!neg_q) begin
			mean = (div_rsp.quotient > SUM_W'(32767)) ? 16'sd32767
				: 16'(div_rsp.quotient);
		end else begin
			mean = (div_rsp.quotient > SUM_W'(32768)) ? -16'sd32768
				: 16'(-div_rsp.quotient);
		end
	end

	// memory ports and divider requests
	always_comb begin
		cen_we    = 1'b0;
		cen_waddr = {ci_q[CW-1:0], di_q[DW-1:0]};
		cen_wdata = mean;
		cen_re    = 1'b0;
		cen_raddr = {j_q[CW-1:0], k_q[DW-1:0]};
		sum_we    = 1'b0;
		sum_waddr = {best_q[CW-1:0], k_q[DW-1:0]};
		sum_wdata = sum_new;
		sum_re    = 1'b0;
		sum_raddr = {j_q[CW-1:0], k_q[DW-1:0]};
		div_req.start    = 1'b0;
		div_req.dividend = mag;
		div_req.divisor  = cur_cnt_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && kind == KIND_WRITE && in_range_w) begin
					cen_we    = 1'b1;
					cen_waddr = {cluster_index[CW-1:0], dim_index[DW-1:0]};
					cen_wdata = value;
				end
			end
			S_DRD:  cen_re = 1'b1;
			S_RDA: begin
				cen_re    = 1'b1;
				cen_raddr = {ci_q[CW-1:0], di_q[DW-1:0]};
			end
			S_SRD: begin
				sum_re    = 1'b1;
				sum_raddr = {best_q[CW-1:0], k_q[DW-1:0]};
			end
			S_SWR:  sum_we = 1'b1;
			S_FRD:  sum_re = 1'b1;
			S_FDW: begin
				if (fsub_q == F_DS) begin
					div_req.start = 1'b1;
				end else if (div_rsp.done) begin
					cen_we    = 1'b1;
					cen_waddr = {j_q[CW-1:0], k_q[DW-1:0]};
				end
			end
			S_FW: begin
				if (fsub_q == F_NONE && total_q != '0) begin
					div_req.start    = 1'b1;
					div_req.dividend = {cur_cnt_q, 16'd0};
					div_req.divisor  = total_q;
				end
			end
			default: ;
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_clusters_q <= 5'd16;
			act_dims_q     <= 5'd16;
			sum_seed_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CLUSTERS: act_clusters_q <= cfg_data[4:0];
				CFG_DIMS:     act_dims_q     <= cfg_data[4:0];
				CFG_SEED:     sum_seed_q     <= cfg_data;
				default:      ;
			endcase
		end
	end

	// sample buffer, no reset
	always_ff @(posedge clk) begin
		if (accept && kind == KIND_SAMPLE && comp_cnt_q < 5'(ED)) begin
			buf_q[comp_cnt_q[DW-1:0]] <= value;
		end
	end

	// squared difference, registered before the accumulate
	always_ff @(posedge clk) begin
		if (state_q == S_DMUL) begin
			prod_s1 <= 33'(z * z);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fsub_q      <= F_NONE;
			comp_cnt_q  <= '0;
			total_q     <= '0;
			fresh_q     <= '1;
			pass_seed_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NROW; i++) counts_q[i] <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						ci_q <= cluster_index;
						di_q <= dim_index;
						in_range_q <= in_range_w;
						case (kind)
							KIND_SAMPLE: begin
								if ((comp_cnt_q + 5'd1) >= nd) begin
									comp_cnt_q <= '0;
									j_q        <= '0;
									k_q        <= '0;
									acc_q      <= '0;
									state_q    <= S_DRD;
								end else begin
									comp_cnt_q <= comp_cnt_q + 5'd1;
								end
							end
							KIND_BEGIN: begin
								for (int i = 0; i < NROW; i++) counts_q[i] <= '0;
								total_q     <= '0;
								fresh_q     <= '1;
								pass_seed_q <= sum_seed_q;
								comp_cnt_q  <= '0;
							end
							KIND_FINISH: begin
								j_q     <= '0;
								state_q <= S_FCHK;
							end
							KIND_READ: state_q <= S_RDA;
							default: ;
						endcase
					end
				end
				S_DRD:  state_q <= S_DMUL;
				S_DMUL: state_q <= S_DACC;
				S_DACC: begin
					acc_q <= acc_q + DIST_W'(prod_s1);
					if (k_last_nd) begin
						state_q <= S_DCMP;
					end else begin
						k_q     <= k_q + 5'd1;
						state_q <= S_DRD;
					end
				end
				S_DCMP: begin
					if (j_q == '0 || acc_q < bestd_q) begin
						bestd_q <= acc_q;
						best_q  <= j_q[3:0];
					end
					acc_q <= '0;
					k_q   <= '0;
					if (j_last) begin
						state_q <= S_CNT;
					end else begin
						j_q     <= j_q + 5'd1;
						state_q <= S_DRD;
					end
				end
				S_CNT: begin
					if (counts_q[best_q[CW-1:0]] != '1) begin
						counts_q[best_q[CW-1:0]] <= counts_q[best_q[CW-1:0]] + 1'b1;
					end
					if (total_q != '1) total_q <= total_q + 1'b1;
					state_q <= S_SRD;
				end
				S_SRD: state_q <= S_SWR;
				S_SWR: begin
					if (k_last_ed) begin
						fresh_q[best_q[CW-1:0]] <= 1'b0;
						state_q <= S_AOUT;
					end else begin
						k_q     <= k_q + 5'd1;
						state_q <= S_SRD;
					end
				end
				S_AOUT: begin
					if (slot_free) begin
						result_kind       <= RES_ASSIGN;
						cluster_index_res <= best_q;
						log_likelihood    <= (bestd_q > DIST_SAT) ? -LL_W'(DIST_SAT)
							: -LL_W'(bestd_q);
						read_value        <= '0;
						weight            <= '0;
						empty_res         <= 1'b0;
						last              <= 1'b0;
						state_q           <= S_IDLE;
					end
				end
				S_RDA: state_q <= S_RDOUT;
				S_RDOUT: begin
					if (slot_free) begin
						result_kind       <= RES_READ;
						cluster_index_res <= ci_q;
						log_likelihood    <= '0;
						read_value        <= in_range_q ? cen_rdata : 16'sd0;
						weight            <= '0;
						empty_res         <= 1'b0;
						last              <= 1'b0;
						state_q           <= S_IDLE;
					end
				end
				S_FCHK: begin
					cur_cnt_q <= row_cnt;
					k_q       <= '0;
					fsub_q    <= F_NONE;
					state_q   <= (row_cnt != '0) ? S_FRD : S_FW;
				end
				S_FRD: begin
					fsub_q  <= F_DS;
					state_q <= S_FDW;
				end
				S_FDW: begin
					if (fsub_q == F_DS) begin
						neg_q  <= sum_old[SUM_W-1];
						fsub_q <= F_NONE;
					end else if (div_rsp.done) begin
						if (k_last_nd) begin
							state_q <= S_FW;
						end else begin
							k_q     <= k_q + 5'd1;
							state_q <= S_FRD;
						end
					end
				end
				S_FW: begin
					unique case (fsub_q)
						F_NONE: begin
							if (total_q != '0) begin
								fsub_q <= F_WW;
							end else begin
								wgt_q  <= '0;
								fsub_q <= F_DS;
							end
						end
						F_WW: begin
							if (div_rsp.done) begin
								wgt_q  <= (div_rsp.quotient > SUM_W'(65536)) ? 17'd65536
									: div_rsp.quotient[16:0];
								fsub_q <= F_DS;
							end
						end
						F_DS: begin
							// weight ready, hand out the update result
							if (slot_free) begin
								result_kind       <= RES_UPDATE;
								cluster_index_res <= j_q[3:0];
								log_likelihood    <= '0;
								read_value        <= '0;
								weight            <= wgt_q;
								empty_res         <= (cur_cnt_q == '0);
								last              <= j_last;
								fsub_q            <= F_NONE;
								if (j_last) begin
									state_q <= S_IDLE;
								end else begin
									j_q     <= j_q + 5'd1;
									state_q <= S_FCHK;
								end
							end
						end
						default: ;
					endcase
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: sv/kaau_chk.sv
// port-level checker for the k-means block, bound to the top level
module kaau_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  result_kind,
	input logic [36:0] log_likelihood,
	input logic [15:0] read_value,
	input logic [16:0] weight,
	input logic        empty_res,
	input logic        last
);
	import kaau_pkg::*;

	// a held result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> result_kind != RES_NONE)
		else $error("unknown result kind");

	a_assign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == RES_ASSIGN |->
		weight == '0 && !empty_res && !last && read_value == '0 &&
		(log_likelihood[36] || log_likelihood == '0))
		else $error("bad assignment result");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == RES_UPDATE && empty_res |-> weight == '0)
		else $error("empty cluster with weight");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> result_kind == RES_UPDATE)
		else $error("last flag outside an update run");

endmodule

bind kmeans_assign_accumulate_update kaau_chk u_kaau_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.result_kind    (result_kind),
	.log_likelihood (log_likelihood),
	.read_value     (read_value),
	.weight         (weight),
	.empty_res      (empty_res),
	.last           (last)
);
